[hdl/fsrm_pkg.sv]
// Shared opcodes, status codes and record types of the frame slot ring manager.
package fsrm_pkg;

   localparam logic [2:0] OP_FILL  = 3'd0;
   localparam logic [2:0] OP_TAKE  = 3'd1;
   localparam logic [2:0] OP_REF   = 3'd2;
   localparam logic [2:0] OP_UNREF = 3'd3;
   localparam logic [2:0] OP_OPEN  = 3'd4;
   localparam logic [2:0] OP_CLOSE = 3'd5;

   localparam logic [3:0] STAT_FILLED     = 4'd0;
   localparam logic [3:0] STAT_DROPPED    = 4'd1;
   localparam logic [3:0] STAT_IGNORED    = 4'd2;
   localparam logic [3:0] STAT_TAKEN      = 4'd3;
   localparam logic [3:0] STAT_NONE_READY = 4'd4;
   localparam logic [3:0] STAT_REF        = 4'd5;
   localparam logic [3:0] STAT_UNREF      = 4'd6;
   localparam logic [3:0] STAT_OPENED     = 4'd7;
   localparam logic [3:0] STAT_CLOSED     = 4'd8;
   localparam logic [3:0] STAT_INCOMPLETE = 4'd9;

   // flags: bit 0 full range, bit 1 bt709
   typedef struct packed {
      logic [7:0]  refs;
      logic [31:0] seq;
      logic [1:0]  flags;
   } slot_entry_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] starved;
      logic [31:0] format;
      logic [13:0] width;
      logic [13:0] height;
   } chan_rec_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [1:0]  result_slot;
      logic [31:0] sequence_res;
      logic        range_full;
      logic        bt709;
      logic [7:0]  ref_count;
      logic [31:0] starved;
      logic        geometry_reset;
   } rsp_type;

endpackage

[hdl/frame_slot_ring_manager.sv]
// Frame slot ring manager: slot bookkeeping per channel over a slot memory and a channel memory.
// Fill and take walk the channel's slots one per cycle in the scan state.
// Ref, unref, open, close and undefined ops do not walk the ring.
// A word passes the scan, update and response states; no new word is taken until the result is loaded.
// Synchronous reset clears control and the per-entry valid flags; stores read as zero until
// written, so there is no clearing pass and the block is ready right after reset.
module frame_slot_ring_manager #(
   parameter int RING_SLOTS = 4,
   parameter int CHANNELS   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_channel,
   input  logic [1:0]  req_slot_index,
   input  logic [31:0] req_pixel_format,
   input  logic [13:0] req_frame_width,
   input  logic [13:0] req_frame_height,
   input  logic        req_full_range,
   input  logic        req_bt709,
   input  logic        req_planes_complete,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_result_slot,
   output logic [31:0] rsp_sequence_res,
   output logic        rsp_out_full_range,
   output logic        rsp_out_bt709,
   output logic [7:0]  rsp_ref_count_now,
   output logic [31:0] rsp_starved_total,
   output logic        rsp_geometry_reset
);

   localparam int NS     = CHANNELS * RING_SLOTS;
   localparam int SW     = $clog2(NS);
   localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RW     = $clog2(RING_SLOTS);
   localparam int SLOT_W = $bits(fsrm_pkg::slot_entry_type);
   localparam int CHAN_W = $bits(fsrm_pkg::chan_rec_type);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_RESP} state_type;

   state_type             state_ff;
   logic [2:0]            op_ff;
   logic [CW-1:0]         ch_ff;
   logic [1:0]            si_ff;
   logic [31:0]           fmt_ff;
   logic [13:0]           w_ff;
   logic [13:0]           h_ff;
   logic [1:0]            flags_ff;
   logic                  complete_ff;
   logic [RW-1:0]         cnt_ff;
   logic [SW-1:0]         scan_addr_ff;
   logic [RW-1:0]         pick_idx_ff;
   logic                  pick_valid_ff;
   logic                  free_found_ff;
   logic [31:0]           pick_seq_ff;
   logic [1:0]            pick_flags_ff;
   logic [7:0]            pick_refs_ff;
   fsrm_pkg::rsp_type     res_ff;
   fsrm_pkg::rsp_type     rsp_ff;
   logic                  rsp_valid_ff;
   logic [NS-1:0]         ready_ff;
   logic [NS-1:0]         written_ff;
   logic [NS-1:0]         live_ff;
   logic [CHANNELS-1:0]   open_ff;
   logic [CHANNELS-1:0]   chan_valid_ff;

   logic                  accept;
   logic                  rsp_load;
   logic [1:0]            ch_wrap;
   logic [CW-1:0]         req_ch;
   logic                  req_refop;
   logic                  op_refop;
   logic                  last_scan;
   logic                  si_ok;
   logic                  slot_rd_en;
   logic [SW-1:0]         slot_rd_addr;
   logic [SLOT_W-1:0]     slot_rd_raw;
   logic [CHAN_W-1:0]     chan_rd_raw;
   fsrm_pkg::slot_entry_type slot_rd;
   fsrm_pkg::slot_entry_type slot_eff;
   fsrm_pkg::chan_rec_type   chan_rd;
   fsrm_pkg::chan_rec_type   chan_eff;
   logic                  geom_mis;
   logic                  fill_reset;
   logic [7:0]            e_refs;
   logic                  e_ready;
   logic [SW-1:0]         pick_addr;
   logic [31:0]           seq_next;
   logic [7:0]            refs_up;
   logic [7:0]            refs_down;

   logic                     slot_wr_en;
   fsrm_pkg::slot_entry_type slot_wr_data;
   logic                     chan_wr_en;
   fsrm_pkg::chan_rec_type   chan_wr_data;
   logic                     ready_clr;
   logic                     live_clr;
   logic                     ready_set;
   logic                     open_set;
   logic                     open_clr;
   fsrm_pkg::rsp_type        res_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // wrap the channel index into range
   always_comb begin
      ch_wrap = req_channel;
      for (int i = 0; i < 3; i++) begin
         if (int'(ch_wrap) >= CHANNELS) begin
            ch_wrap = ch_wrap - 2'(CHANNELS);
         end
      end
   end
   assign req_ch = CW'(ch_wrap);

   assign req_refop = (req_op == fsrm_pkg::OP_REF) || (req_op == fsrm_pkg::OP_UNREF);
   assign op_refop  = (op_ff == fsrm_pkg::OP_REF) || (op_ff == fsrm_pkg::OP_UNREF);
   assign last_scan = ((op_ff == fsrm_pkg::OP_FILL) || (op_ff == fsrm_pkg::OP_TAKE)) ?
                      (int'(cnt_ff) == RING_SLOTS - 1) : 1'b1;
   assign si_ok     = int'(si_ff) < RING_SLOTS;

   always_comb begin
      slot_rd_en   = 1'b0;
      slot_rd_addr = scan_addr_ff;
      if (accept) begin
         slot_rd_en = 1'b1;
         if (req_refop && (int'(req_slot_index) < RING_SLOTS)) begin
            slot_rd_addr = SW'(int'(req_ch) * RING_SLOTS + int'(req_slot_index));
         end else begin
            slot_rd_addr = SW'(int'(req_ch) * RING_SLOTS);
         end
      end else if (state_ff == ST_SCAN && !last_scan) begin
         slot_rd_en   = 1'b1;
         slot_rd_addr = SW'(int'(ch_ff) * RING_SLOTS + int'(cnt_ff) + 1);
      end
   end

   assign pick_addr = SW'(int'(ch_ff) * RING_SLOTS + int'(pick_idx_ff));

   fsrm_ram #(
      .DATA_W (SLOT_W),
      .DEPTH  (NS),
      .ADDR_W (SW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (pick_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_raw)
   );

   fsrm_ram #(
      .DATA_W (CHAN_W),
      .DEPTH  (CHANNELS),
      .ADDR_W (CW)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_wr_en),
      .wr_addr (ch_ff),
      .wr_data (chan_wr_data),
      .rd_en   (accept),
      .rd_addr (req_ch),
      .rd_data (chan_rd_raw)
   );

   assign slot_rd = fsrm_pkg::slot_entry_type'(slot_rd_raw);
   assign chan_rd = fsrm_pkg::chan_rec_type'(chan_rd_raw);

   // entries never written read as zero
   always_comb begin
      slot_eff.refs  = live_ff[scan_addr_ff] ? slot_rd.refs : 8'd0;
      slot_eff.seq   = written_ff[scan_addr_ff] ? slot_rd.seq : 32'd0;
      slot_eff.flags = written_ff[scan_addr_ff] ? slot_rd.flags : 2'd0;
      chan_eff       = chan_valid_ff[ch_ff] ? chan_rd : '0;
   end

   assign geom_mis   = (chan_eff.format != fmt_ff) || (chan_eff.width != w_ff) ||
                       (chan_eff.height != h_ff);
   assign fill_reset = (op_ff == fsrm_pkg::OP_FILL) && geom_mis;
   assign e_refs     = fill_reset ? 8'd0 : slot_eff.refs;
   assign e_ready    = !fill_reset && ready_ff[scan_addr_ff];
   assign seq_next   = chan_eff.seq + 32'd1;
   assign refs_up    = (pick_refs_ff != 8'hFF) ? pick_refs_ff + 8'd1 : pick_refs_ff;
   assign refs_down  = (pick_refs_ff != 8'd0) ? pick_refs_ff - 8'd1 : pick_refs_ff;

   // write back and build the result word
   always_comb begin
      slot_wr_en   = 1'b0;
      slot_wr_data = '0;
      chan_wr_en   = 1'b0;
      chan_wr_data = chan_eff;
      ready_clr    = 1'b0;
      live_clr     = 1'b0;
      ready_set    = 1'b0;
      open_set     = 1'b0;
      open_clr     = 1'b0;
      res_in       = '0;
      res_in.status = fsrm_pkg::STAT_IGNORED;
      if (state_ff == ST_UPDATE) begin
         case (op_ff)
            fsrm_pkg::OP_FILL: begin
               if (open_ff[ch_ff]) begin
                  if (geom_mis) begin
                     ready_clr           = 1'b1;
                     live_clr            = 1'b1;
                     chan_wr_en          = 1'b1;
                     chan_wr_data.format = fmt_ff;
                     chan_wr_data.width  = w_ff;
                     chan_wr_data.height = h_ff;
                     res_in.geometry_reset = 1'b1;
                  end
                  if (!pick_valid_ff) begin
                     chan_wr_en = 1'b1;
                     if (chan_eff.starved != 32'hFFFF_FFFF) begin
                        chan_wr_data.starved = chan_eff.starved + 32'd1;
                     end
                     res_in.status = fsrm_pkg::STAT_DROPPED;
                  end else if (!complete_ff) begin
                     res_in.status = fsrm_pkg::STAT_INCOMPLETE;
                  end else begin
                     chan_wr_en         = 1'b1;
                     chan_wr_data.seq   = seq_next;
                     slot_wr_en         = 1'b1;
                     slot_wr_data.refs  = 8'd0;
                     slot_wr_data.seq   = seq_next;
                     slot_wr_data.flags = flags_ff;
                     ready_set          = 1'b1;
                     res_in.status       = fsrm_pkg::STAT_FILLED;
                     res_in.result_slot  = 2'(pick_idx_ff);
                     res_in.sequence_res = seq_next;
                     res_in.range_full   = flags_ff[0];
                     res_in.bt709        = flags_ff[1];
                  end
               end
            end
            fsrm_pkg::OP_TAKE: begin
               if (pick_valid_ff) begin
                  ready_clr          = 1'b1;
                  slot_wr_en         = 1'b1;
                  slot_wr_data.refs  = 8'd1;
                  slot_wr_data.seq   = pick_seq_ff;
                  slot_wr_data.flags = pick_flags_ff;
                  res_in.status       = fsrm_pkg::STAT_TAKEN;
                  res_in.result_slot  = 2'(pick_idx_ff);
                  res_in.sequence_res = pick_seq_ff;
                  res_in.range_full   = pick_flags_ff[0];
                  res_in.bt709        = pick_flags_ff[1];
                  res_in.ref_count    = 8'd1;
               end else begin
                  res_in.status = fsrm_pkg::STAT_NONE_READY;
               end
            end
            fsrm_pkg::OP_REF, fsrm_pkg::OP_UNREF: begin
               res_in.status = (op_ff == fsrm_pkg::OP_REF) ? fsrm_pkg::STAT_REF :
                               fsrm_pkg::STAT_UNREF;
               if (si_ok) begin
                  slot_wr_en         = 1'b1;
                  slot_wr_data.refs  = (op_ff == fsrm_pkg::OP_REF) ? refs_up : refs_down;
                  slot_wr_data.seq   = pick_seq_ff;
                  slot_wr_data.flags = pick_flags_ff;
                  res_in.result_slot  = si_ff;
                  res_in.sequence_res = pick_seq_ff;
                  res_in.range_full   = pick_flags_ff[0];
                  res_in.bt709        = pick_flags_ff[1];
                  res_in.ref_count    = slot_wr_data.refs;
               end
            end
            fsrm_pkg::OP_OPEN: begin
               open_set             = 1'b1;
               chan_wr_en           = 1'b1;
               chan_wr_data.starved = 32'd0;
               res_in.status        = fsrm_pkg::STAT_OPENED;
            end
            fsrm_pkg::OP_CLOSE: begin
               open_clr      = 1'b1;
               ready_clr     = 1'b1;
               res_in.status = fsrm_pkg::STAT_CLOSED;
            end
            default: begin
               res_in.status = fsrm_pkg::STAT_IGNORED;
            end
         endcase
         res_in.starved = chan_wr_data.starved;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pick_valid_ff <= 1'b0;
         free_found_ff <= 1'b0;
         ready_ff      <= '0;
         written_ff    <= '0;
         live_ff       <= '0;
         open_ff       <= '0;
         chan_valid_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (slot_rd_en) begin
            scan_addr_ff <= slot_rd_addr;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff         <= req_op;
                  ch_ff         <= req_ch;
                  si_ff         <= req_slot_index;
                  fmt_ff        <= req_pixel_format;
                  w_ff          <= req_frame_width;
                  h_ff          <= req_frame_height;
                  flags_ff      <= {req_bt709, req_full_range};
                  complete_ff   <= req_planes_complete;
                  cnt_ff        <= '0;
                  pick_idx_ff   <= RW'(req_slot_index);
                  pick_valid_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               case (op_ff)
                  fsrm_pkg::OP_FILL: begin
                     // first unheld empty slot wins, else the oldest unheld ready one
                     if (!free_found_ff && e_refs == 8'd0) begin
                        if (!e_ready) begin
                           pick_idx_ff   <= cnt_ff;
                           pick_valid_ff <= 1'b1;
                           free_found_ff <= 1'b1;
                        end else if (!pick_valid_ff || slot_eff.seq < pick_seq_ff) begin
                           pick_idx_ff   <= cnt_ff;
                           pick_valid_ff <= 1'b1;
                           pick_seq_ff   <= slot_eff.seq;
                        end
                     end
                  end
                  fsrm_pkg::OP_TAKE: begin
                     if (e_ready && (!pick_valid_ff || slot_eff.seq > pick_seq_ff)) begin
                        pick_idx_ff   <= cnt_ff;
                        pick_valid_ff <= 1'b1;
                        pick_seq_ff   <= slot_eff.seq;
                        pick_flags_ff <= slot_eff.flags;
                     end
                  end
                  default: begin
                     if (op_refop) begin
                        pick_seq_ff   <= slot_eff.seq;
                        pick_flags_ff <= slot_eff.flags;
                        pick_refs_ff  <= slot_eff.refs;
                     end
                  end
               endcase
               cnt_ff <= cnt_ff + RW'(1);
               if (last_scan) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               res_ff   <= res_in;
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               // hold until the output register is free
               if (rsp_load) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // the written slot keeps its marks over a channel-wide clear
         for (int i = 0; i < NS; i++) begin
            if (slot_wr_en && (i == int'(pick_addr))) begin
               written_ff[i] <= 1'b1;
               live_ff[i]    <= 1'b1;
            end else if (live_clr && ((i / RING_SLOTS) == int'(ch_ff))) begin
               live_ff[i] <= 1'b0;
            end
            if (ready_set && (i == int'(pick_addr))) begin
               ready_ff[i] <= 1'b1;
            end else if (ready_clr && ((i / RING_SLOTS) == int'(ch_ff))) begin
               ready_ff[i] <= 1'b0;
            end
         end
         if (chan_wr_en) begin
            chan_valid_ff[ch_ff] <= 1'b1;
         end
         if (open_set) begin
            open_ff[ch_ff] <= 1'b1;
         end
         if (open_clr) begin
            open_ff[ch_ff] <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_result_slot    = rsp_ff.result_slot;
   assign rsp_sequence_res   = rsp_ff.sequence_res;
   assign rsp_out_full_range = rsp_ff.range_full;
   assign rsp_out_bt709      = rsp_ff.bt709;
   assign rsp_ref_count_now  = rsp_ff.ref_count;
   assign rsp_starved_total  = rsp_ff.starved;
   assign rsp_geometry_reset = rsp_ff.geometry_reset;

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted word did not start a scan");

   a_write_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (slot_wr_en || chan_wr_en) |-> state_ff == ST_UPDATE)
      else $error("memory write outside the update step");

   a_ready_mark_with_write: assert property (@(posedge clock) disable iff (reset)
      ready_set |-> slot_wr_en)
      else $error("slot marked ready without writing its entry");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result word not presented");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status <= fsrm_pkg::STAT_INCOMPLETE)
      else $error("result status out of range");

endmodule

[hdl/fsrm_ram.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
module fsrm_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
